### hw/rtl/lfr_pkg.sv
`default_nettype none
package lfr_pkg;

  localparam logic [7:0] HDR_DATA = 8'h59;
  localparam logic [7:0] HDR_RESP = 8'h5A;

  localparam int DATA_BYTES         = 9;
  localparam int MIN_RESPONSE_BYTES = 3;

  // only frame bytes 2..7 are ever looked at once a frame closes
  localparam int STORE_LO = 2;
  localparam int STORE_HI = 7;
  localparam int ID_BYTE  = 2;
  localparam int WORD_LO  = 3;
  localparam int WORD_HI  = 6;

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_LEN,
    PH_DATA,
    PH_RESP
  } lfr_phase_t;

  typedef struct packed {
    logic        checksum_ok;
    logic        is_response;
    logic [15:0] distance;
    logic [15:0] strength;
    logic [15:0] raw_temperature;
    logic [3:0]  response_length;
    logic [7:0]  response_id;
    logic [31:0] response_word;
  } lfr_result_t;

endpackage
`default_nettype wire

### hw/rtl/lfr_if.sv
`default_nettype none
interface lfr_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface lfr_cfg_if;
  logic valid;
  logic ready;
  logic hunt_command;
  modport source (output valid, output hunt_command, input ready);
  modport sink   (input valid, input hunt_command, output ready);
endinterface

interface lfr_frame_if;
  logic        valid;
  logic        ready;
  logic        checksum_ok;
  logic        is_response;
  logic [15:0] distance;
  logic [15:0] strength;
  logic [15:0] raw_temperature;
  logic [3:0]  response_length;
  logic [7:0]  response_id;
  logic [31:0] response_word;
  modport source (output valid, output checksum_ok, output is_response, output distance,
                  output strength, output raw_temperature, output response_length,
                  output response_id, output response_word, input ready);
  modport sink   (input valid, input checksum_ok, input is_response, input distance,
                  input strength, input raw_temperature, input response_length,
                  input response_id, input response_word, output ready);
endinterface
`default_nettype wire

### hw/rtl/lidar_frame_receiver_unit.sv
// A frame's closing byte is held in the input stage, then the parser assembles its result
//   combinationally, which is loaded into the result register when that register has room.
// Throughput: one byte beat per cycle while the result register is empty or draining;
//   the parser state update is the only loop.
// Reset (rst, synchronous, active high): hunting, counters and sum cleared,
//   hunt_command 0, no beats held. The byte store needs no clearing.
`default_nettype none
module lidar_frame_receiver_unit import lfr_pkg::*; #(
  parameter int MAX_RESPONSE_BYTES = 8
) (
  input  wire logic   clk,
  input  wire logic   rst,
  lfr_byte_if.sink    rx,
  lfr_cfg_if.sink     cfg,
  lfr_frame_if.source frame
);

  logic        stage_valid;
  logic [7:0]  stage_byte;
  logic        space;
  logic        step;
  logic        res_valid;
  lfr_result_t res;

  // register write is always taken; writes must only arrive while idle, which the block does not enforce
  assign cfg.ready = 1'b1;

  // a held byte moves into the parser once the result register has room,
  // whether or not this byte closes a frame
  assign step = stage_valid && space;

  lfr_in_stage u_in (
    .clk         (clk),
    .rst         (rst),
    .rx          (rx),
    .take        (step),
    .stage_valid (stage_valid),
    .stage_byte  (stage_byte)
  );

  // header hunt, length check, running sum and result assembly
  lfr_parser #(
    .MAX_RESPONSE_BYTES (MAX_RESPONSE_BYTES)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .rx_byte   (stage_byte),
    .cfg_we    (cfg.valid && cfg.ready),
    .cfg_hunt  (cfg.hunt_command),
    .res_valid (res_valid),
    .res       (res)
  );

  // result register: a finished frame waits here, and the parser stalls until the sink takes it
  lfr_out_reg u_out (
    .clk   (clk),
    .rst   (rst),
    .load  (step && res_valid),
    .res   (res),
    .space (space),
    .frame (frame)
  );

endmodule
`default_nettype wire

### hw/rtl/lfr_in_stage.sv
`default_nettype none
module lfr_in_stage (
  input  wire logic  clk,
  input  wire logic  rst,
  lfr_byte_if.sink   rx,
  input  wire logic  take,
  output logic       stage_valid,
  output logic [7:0] stage_byte
);

  assign rx.ready = !stage_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (rx.valid && rx.ready) begin
      stage_valid <= 1'b1;
    end else if (take) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      stage_byte <= rx.rx_byte;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/lfr_parser.sv
`default_nettype none
module lfr_parser import lfr_pkg::*; #(
  parameter int MAX_RESPONSE_BYTES = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        step,
  input  wire logic [7:0]  rx_byte,
  input  wire logic        cfg_we,
  input  wire logic        cfg_hunt,
  output logic             res_valid,
  output lfr_result_t      res
);

  localparam int FRAME_MAX = (MAX_RESPONSE_BYTES > DATA_BYTES) ? MAX_RESPONSE_BYTES
                                                                : DATA_BYTES;
  localparam int IDX_W = $clog2(FRAME_MAX);
  localparam int LEN_W = $clog2(FRAME_MAX + 1);

  logic             hunt_command;
  lfr_phase_t       phase, phase_next;
  logic [IDX_W-1:0] byte_index, byte_index_next;
  logic [LEN_W-1:0] frame_length, frame_length_next;
  logic [7:0]       running_sum, running_sum_next;
  logic [7:0]       frame_bytes [STORE_LO:STORE_HI];

  logic [7:0]       view [STORE_LO:STORE_HI];
  logic             hdr_hit;
  logic             len_bad;
  logic             more;
  logic             store_we;
  logic [LEN_W:0]   idx_plus;

  // current byte bypasses the store: it may be the checksum byte itself
  always_comb begin
    for (int k = STORE_LO; k <= STORE_HI; k++) begin
      view[k] = (byte_index == IDX_W'(k)) ? rx_byte : frame_bytes[k];
    end
  end

  assign hdr_hit  = hunt_command ? (rx_byte == HDR_RESP) : (rx_byte == HDR_DATA);
  assign len_bad  = (rx_byte < 8'(MIN_RESPONSE_BYTES)) ||
                    (rx_byte > 8'(MAX_RESPONSE_BYTES));
  assign idx_plus = (LEN_W + 1)'(byte_index) + 1'b1;
  assign more     = idx_plus < {1'b0, frame_length};
  assign store_we = step && (phase == PH_DATA || phase == PH_RESP);

  always_comb begin
    logic [31:0] word;
    word              = '0;
    phase_next        = phase;
    byte_index_next   = byte_index;
    frame_length_next = frame_length;
    running_sum_next  = running_sum;
    res_valid         = 1'b0;
    res               = '0;
    if (step) begin
      case (phase)
        PH_HUNT: begin
          if (hdr_hit) begin
            running_sum_next = rx_byte;
            byte_index_next  = IDX_W'(1);
            if (hunt_command) begin
              frame_length_next = '0;
              phase_next        = PH_LEN;
            end else begin
              frame_length_next = LEN_W'(DATA_BYTES);
              phase_next        = PH_DATA;
            end
          end
        end
        PH_LEN: begin
          if (len_bad) begin
            res_valid       = 1'b1;
            res.is_response = 1'b1;
            phase_next      = PH_HUNT;
            byte_index_next = '0;
          end else begin
            running_sum_next  = running_sum + rx_byte;
            frame_length_next = rx_byte[LEN_W-1:0];
            byte_index_next   = IDX_W'(2);
            phase_next        = PH_RESP;
          end
        end
        PH_DATA, PH_RESP: begin
          if (more) begin
            running_sum_next = running_sum + rx_byte;
            byte_index_next  = byte_index + IDX_W'(1);
          end else begin
            res_valid       = 1'b1;
            res.checksum_ok = (rx_byte == running_sum);
            if (phase == PH_DATA) begin
              if (res.checksum_ok) begin
                res.distance        = {view[3], view[2]};
                res.strength        = {view[5], view[4]};
                res.raw_temperature = {view[7], view[6]};
              end
            end else begin
              res.is_response     = 1'b1;
              res.response_length = 4'(frame_length);
              res.response_id     = view[ID_BYTE];
              for (int k = WORD_LO; k <= WORD_HI; k++) begin
                word = {word[23:0],
                        ((LEN_W + 1)'(k) < {1'b0, frame_length}) ? view[k] : 8'h00};
              end
              res.response_word = word;
            end
            phase_next      = PH_HUNT;
            byte_index_next = '0;
          end
        end
        default: begin
          phase_next = PH_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hunt_command <= 1'b0;
      phase        <= PH_HUNT;
      byte_index   <= '0;
      frame_length <= '0;
      running_sum  <= '0;
    end else begin
      if (cfg_we) begin
        hunt_command <= cfg_hunt;
      end
      phase        <= phase_next;
      byte_index   <= byte_index_next;
      frame_length <= frame_length_next;
      running_sum  <= running_sum_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = STORE_LO; k <= STORE_HI; k++) begin
      if (store_we && byte_index == IDX_W'(k)) begin
        frame_bytes[k] <= rx_byte;
      end
    end
  end

  a_hunt_idx: assert property (@(posedge clk) disable iff (rst)
    phase == PH_HUNT |-> byte_index == '0)
    else $error("byte index not cleared while hunting");

  a_data_len: assert property (@(posedge clk) disable iff (rst)
    phase == PH_DATA |-> frame_length == LEN_W'(DATA_BYTES))
    else $error("data frame length lost");

  a_reject: assert property (@(posedge clk) disable iff (rst)
    step && phase == PH_LEN && len_bad |=> phase == PH_HUNT && byte_index == '0)
    else $error("rejected length did not return to hunt");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.is_response && !res.checksum_ok |->
      res.distance == '0 && res.strength == '0 && res.raw_temperature == '0)
    else $error("failed data frame carries measurements");

endmodule
`default_nettype wire

### hw/rtl/lfr_out_reg.sv
`default_nettype none
module lfr_out_reg import lfr_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        load,
  input  wire lfr_result_t res,
  output logic             space,
  lfr_frame_if.source      frame
);

  lfr_result_t held;

  assign space = !frame.valid || frame.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame.valid <= 1'b0;
    end else if (load) begin
      frame.valid <= 1'b1;
    end else if (frame.ready) begin
      frame.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= res;
    end
  end

  assign frame.checksum_ok     = held.checksum_ok;
  assign frame.is_response     = held.is_response;
  assign frame.distance        = held.distance;
  assign frame.strength        = held.strength;
  assign frame.raw_temperature = held.raw_temperature;
  assign frame.response_length = held.response_length;
  assign frame.response_id     = held.response_id;
  assign frame.response_word   = held.response_word;

endmodule
`default_nettype wire
